// ===== sv/stp_pkg.sv =====
// ============================================================================
// String to integer parser - shared definitions
// Types, codes and character constants used by the controller, the datapath
// and the channel interfaces.
// ============================================================================
package stp_pkg;

    localparam int CHAR_BITS     = 8;
    localparam int BASE_BITS     = 6;
    localparam int DIGIT_BITS    = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 6;
    localparam int STATUS_BITS   = 2;

    localparam logic [BASE_BITS-1:0] MAX_BASE     = 6'd36;
    localparam logic [BASE_BITS-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_ONE     = 6'd1;
    localparam logic [BASE_BITS-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC     = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_BITS-1:0] RADIX_RESET  = BASE_DEC;

    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_LO_X   = 8'h78;
    localparam logic [CHAR_BITS-1:0] LETTER_OFFSET = 8'd10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RADIX       = 2'd0,
        CFG_SIGNED_MODE = 2'd1
    } t_cfg_idx;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_BASE  = 2'd1,
        ST_NO_DIGITS = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_AFTER_SIGN,
        PH_ZERO,
        PH_X,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        BS_KEEP,
        BS_OCT,
        BS_DEC,
        BS_HEX
    } t_base_sel;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_BAD_BASE,
        EM_NO_DIGITS,
        EM_NUMBER,
        EM_LONE_X
    } t_emit;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      step;
        logic      advance;
        logic      append;
        logic      set_sign;
        logic      mark_prefix;
        t_base_sel base_sel;
        t_emit     emit;
    } t_cmd;

    // Status from the datapath to the controller, about the current character.
    typedef struct packed {
        logic start;
        logic bad_base;
        logic space;
        logic sign;
        logic zero;
        logic x;
        logic dec;
        logic base_auto;
        logic base_hex;
        logic ok_cur;
        logic ok_oct;
        logic ok_hex;
        logic out_free;
    } t_cls;

endpackage

// ===== sv/stp_char_if.sv =====
// ============================================================================
// Character channel
// Carries one character of the string and the start marker per request.
// ============================================================================
interface stp_char_if;
    logic                           valid;
    logic                           ready;
    logic [stp_pkg::CHAR_BITS-1:0]  ch;
    logic                           start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

// ===== sv/stp_res_if.sv =====
// ============================================================================
// Result channel
// Carries the converted value, the end offset and the status per request.
// ============================================================================
interface stp_res_if #(
    parameter int VALUE_BITS  = 64,
    parameter int OFFSET_BITS = 16
);
    logic                             valid;
    logic                             ready;
    logic [VALUE_BITS-1:0]            value;
    logic [OFFSET_BITS-1:0]           end_offset;
    logic [stp_pkg::STATUS_BITS-1:0]  status;

    modport source (output valid, output value, output end_offset, output status,
                    input ready);
    modport sink   (input valid, input value, input end_offset, input status,
                    output ready);
endinterface

// ===== sv/stp_cfg_if.sv =====
// ============================================================================
// Configuration write channel
// Carries a register index and the data to write per request.
// ============================================================================
interface stp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [stp_pkg::CFG_IDX_BITS-1:0]   index;
    logic [stp_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/stp_dp.sv =====
// ============================================================================
// String to integer parser - datapath
// Configuration registers, character decode, accumulator with overflow
// detection, position counters and the result register.
// ============================================================================
module stp_dp #(
    parameter int VALUE_BITS  = 64,
    parameter int OFFSET_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [stp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [stp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic [stp_pkg::CHAR_BITS-1:0]     i_ch,
    input  logic                              i_start,
    input  stp_pkg::t_cmd                     i_cmd,
    output stp_pkg::t_cls                     o_cls,
    input  logic                              i_res_ready,
    output logic                              o_res_valid,
    output logic [VALUE_BITS-1:0]             o_value,
    output logic [OFFSET_BITS-1:0]            o_end_offset,
    output logic [stp_pkg::STATUS_BITS-1:0]   o_status
);
    import stp_pkg::*;

    localparam int PROD_BITS = VALUE_BITS + BASE_BITS;
    localparam logic [VALUE_BITS-1:0] TOP_VAL  = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MAX_POS  = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};

    logic [BASE_BITS-1:0]   r_radix;
    logic                   r_signed_mode;
    logic [VALUE_BITS-1:0]  r_acc;
    logic                   r_neg;
    logic                   r_ovf;
    logic                   r_signed;
    logic [BASE_BITS-1:0]   r_base;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_prefix;
    logic                   r_out_valid;
    logic [VALUE_BITS-1:0]  r_value;
    logic [OFFSET_BITS-1:0] r_end;
    t_status                r_status;

    logic [VALUE_BITS-1:0]  n_acc;
    logic                   n_neg;
    logic                   n_ovf;
    logic [BASE_BITS-1:0]   n_base;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [OFFSET_BITS-1:0] n_prefix;
    logic                   n_out_valid;
    logic [VALUE_BITS-1:0]  n_value;
    logic [OFFSET_BITS-1:0] n_end;
    t_status                n_status;

    logic                   is_dec, is_up, is_lo, is_alnum;
    logic [CHAR_BITS-1:0]   dig_wide;
    logic [DIGIT_BITS-1:0]  dig;
    logic [BASE_BITS-1:0]   base_now, eff_base;
    logic                   signed_now;
    logic [VALUE_BITS-1:0]  cur_acc;
    logic                   cur_neg, cur_ovf;
    logic [OFFSET_BITS-1:0] cur_pos, cur_prefix, adv_pos;
    logic [PROD_BITS-1:0]   prod, limit;
    logic [VALUE_BITS-1:0]  num_value;
    logic                   out_free;

    // Character decode, independent of the base.
    always_comb begin
        is_dec   = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        is_up    = (i_ch >= CH_UP_A) && (i_ch <= CH_UP_Z);
        is_lo    = (i_ch >= CH_LO_A) && (i_ch <= CH_LO_Z);
        is_alnum = is_dec || is_up || is_lo;
        if (is_dec) begin
            dig_wide = i_ch - CH_ZERO;
        end else if (is_up) begin
            dig_wide = i_ch - CH_UP_A + LETTER_OFFSET;
        end else begin
            dig_wide = i_ch - CH_LO_A + LETTER_OFFSET;
        end
        dig = dig_wide[DIGIT_BITS-1:0];
    end

    // A start character sees the cleared state and the live configuration.
    always_comb begin
        base_now   = i_start ? r_radix : r_base;
        signed_now = i_start ? r_signed_mode : r_signed;
        cur_acc    = i_start ? '0 : r_acc;
        cur_neg    = i_start ? 1'b0 : r_neg;
        cur_ovf    = i_start ? 1'b0 : r_ovf;
        cur_pos    = i_start ? '0 : r_pos;
        cur_prefix = i_start ? '0 : r_prefix;
        adv_pos    = (cur_pos == {OFFSET_BITS{1'b1}}) ? cur_pos : cur_pos + 1'b1;
        out_free   = !r_out_valid || i_res_ready;
    end

    always_comb begin
        o_cls.start     = i_start;
        o_cls.bad_base  = (r_radix == BASE_ONE) || (r_radix > MAX_BASE);
        o_cls.space     = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
        o_cls.sign      = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
        o_cls.zero      = (i_ch == CH_ZERO);
        o_cls.x         = (i_ch == CH_UP_X) || (i_ch == CH_LO_X);
        o_cls.dec       = is_dec;
        o_cls.base_auto = (base_now == BASE_AUTO);
        o_cls.base_hex  = (base_now == BASE_HEX);
        o_cls.ok_cur    = is_alnum && (dig < base_now);
        o_cls.ok_oct    = is_alnum && (dig < BASE_OCT);
        o_cls.ok_hex    = is_alnum && (dig < BASE_HEX);
        o_cls.out_free  = out_free;
    end

    always_comb begin
        case (i_cmd.base_sel)
            BS_KEEP: eff_base = base_now;
            BS_OCT:  eff_base = BASE_OCT;
            BS_DEC:  eff_base = BASE_DEC;
            BS_HEX:  eff_base = BASE_HEX;
            default: eff_base = base_now;
        endcase
    end

    // Digit append: accumulator * base + digit, checked against the type limit.
    always_comb begin
        prod = PROD_BITS'(cur_acc) * PROD_BITS'(eff_base) + PROD_BITS'(dig);
        if (signed_now) begin
            limit = PROD_BITS'(cur_neg ? TOP_VAL : MAX_POS);
        end else begin
            limit = PROD_BITS'(ALL_ONES);
        end
        n_acc = cur_acc;
        n_ovf = cur_ovf;
        if (i_cmd.append && !cur_ovf && (eff_base >= 6'd2)) begin
            if (!signed_now && cur_neg && (dig != '0)) begin
                n_ovf = 1'b1;
            end else if (prod > limit) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = prod[VALUE_BITS-1:0];
            end
        end
        n_neg    = i_cmd.set_sign ? (i_ch == CH_MINUS) : cur_neg;
        n_base   = eff_base;
        n_pos    = i_cmd.advance ? adv_pos : cur_pos;
        n_prefix = i_cmd.mark_prefix ? cur_pos : cur_prefix;
    end

    // Result formation.
    always_comb begin
        num_value = (cur_neg && signed_now) ? ('0 - cur_acc) : cur_acc;
        n_value   = '0;
        n_end     = '0;
        n_status  = ST_OK;
        case (i_cmd.emit)
            EM_BAD_BASE:  n_status = ST_BAD_BASE;
            EM_NO_DIGITS: n_status = ST_NO_DIGITS;
            EM_LONE_X:    n_end = cur_prefix + 1'b1;
            EM_NUMBER: begin
                n_end = cur_pos;
                if (cur_ovf) begin
                    n_status = ST_RANGE;
                    if (!signed_now) begin
                        n_value = ALL_ONES;
                    end else if (cur_neg) begin
                        n_value = TOP_VAL;
                    end else begin
                        n_value = MAX_POS;
                    end
                end else begin
                    n_value = num_value;
                end
            end
            default: n_status = ST_OK;
        endcase
        if (i_cmd.emit != EM_NONE) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_res_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= RADIX_RESET;
            r_signed_mode <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RADIX:       r_radix <= i_cfg_data;
                    CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                    default:         r_radix <= r_radix;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_ovf    <= n_ovf;
            r_signed <= signed_now;
            r_base   <= n_base;
            r_pos    <= n_pos;
            r_prefix <= n_prefix;
        end
        if (i_cmd.emit != EM_NONE) begin
            r_value  <= n_value;
            r_end    <= n_end;
            r_status <= n_status;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_end_offset = r_end;
    assign o_status     = r_status;

endmodule

// ===== sv/stp_ctrl.sv =====
// ============================================================================
// String to integer parser - controller
// Phase state machine that walks whitespace, sign, prefix and digits and
// commands the datapath.
// ============================================================================
module stp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  stp_pkg::t_cls i_cls,
    output stp_pkg::t_cmd o_cmd
);
    import stp_pkg::*;

    t_phase r_phase;
    t_phase n_phase;
    t_phase ph;
    logic   do_first;
    logic   do_digits;
    logic   dig_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        ph                = i_cls.start ? PH_SPACE : r_phase;
        n_phase           = r_phase;
        do_first          = 1'b0;
        do_digits         = 1'b0;
        dig_ok            = 1'b0;
        o_cmd.step        = i_accept;
        o_cmd.advance     = 1'b0;
        o_cmd.append      = 1'b0;
        o_cmd.set_sign    = 1'b0;
        o_cmd.mark_prefix = 1'b0;
        o_cmd.base_sel    = BS_KEEP;
        o_cmd.emit        = EM_NONE;
        if (i_accept) begin
            n_phase = ph;
            if (i_cls.start && i_cls.bad_base) begin
                o_cmd.emit = EM_BAD_BASE;
                n_phase    = PH_IDLE;
            end else begin
                case (ph)
                    PH_SPACE: begin
                        if (i_cls.space) begin
                            o_cmd.advance = 1'b1;
                        end else if (i_cls.sign) begin
                            o_cmd.set_sign = 1'b1;
                            o_cmd.advance  = 1'b1;
                            n_phase        = PH_AFTER_SIGN;
                        end else begin
                            do_first = 1'b1;
                        end
                    end
                    PH_AFTER_SIGN: do_first = 1'b1;
                    PH_ZERO: begin
                        if (i_cls.x) begin
                            o_cmd.base_sel = BS_HEX;
                            o_cmd.advance  = 1'b1;
                            n_phase        = PH_X;
                        end else begin
                            do_digits = 1'b1;
                            if (i_cls.base_auto) begin
                                o_cmd.base_sel = BS_OCT;
                                dig_ok         = i_cls.ok_oct;
                            end else begin
                                dig_ok = i_cls.ok_cur;
                            end
                        end
                    end
                    PH_X: begin
                        if (!i_cls.ok_hex) begin
                            o_cmd.emit = EM_LONE_X;
                            n_phase    = PH_IDLE;
                        end else begin
                            do_digits = 1'b1;
                            dig_ok    = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        do_digits = 1'b1;
                        dig_ok    = i_cls.ok_cur;
                    end
                    default: n_phase = PH_IDLE;
                endcase

                if (do_first) begin
                    if (i_cls.zero && (i_cls.base_auto || i_cls.base_hex)) begin
                        o_cmd.mark_prefix = 1'b1;
                        o_cmd.advance     = 1'b1;
                        n_phase           = PH_ZERO;
                    end else if (i_cls.base_auto && i_cls.dec) begin
                        o_cmd.base_sel = BS_DEC;
                        do_digits      = 1'b1;
                        dig_ok         = 1'b1;
                    end else if (i_cls.ok_cur) begin
                        do_digits = 1'b1;
                        dig_ok    = 1'b1;
                    end else begin
                        o_cmd.emit = EM_NO_DIGITS;
                        n_phase    = PH_IDLE;
                    end
                end

                if (do_digits) begin
                    if (dig_ok) begin
                        o_cmd.advance = 1'b1;
                        o_cmd.append  = 1'b1;
                        n_phase       = PH_DIGITS;
                    end else begin
                        o_cmd.emit = EM_NUMBER;
                        n_phase    = PH_IDLE;
                    end
                end
            end
        end
    end

endmodule

// ===== sv/string_to_integer_parser.sv =====
// ============================================================================
// String to integer parser - top level
// Converts a NUL-terminated character stream into a signed or unsigned
// integer with strtol-style whitespace, sign and base prefix handling.
// ============================================================================
//
//   Channel   Direction  Request carries
//   --------  ---------  ---------------------------------------------------
//   i_char    in         ch (8 bits), start_req (1 bit)
//   o_res     out        value (VALUE_BITS), end_offset (OFFSET_BITS), status
//   i_cfg     in         index (0 radix, 1 signed_mode), data (6 bits)
//
// When a character is taken, the accumulator multiplies by the base and
// checks for overflow in that same cycle: one character per clock while
// the output register is free. A result sits in the output register from the
// cycle after the character that ends the number. The character channel is
// stalled only while that register still holds a result that has not been
// taken. Reset restores radix 10, signed mode and an idle parser; no
// clearing pass is needed, so characters are taken from the first cycle.
//
module string_to_integer_parser #(
    parameter int VALUE_BITS  = 64,
    parameter int OFFSET_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stp_char_if.sink      i_char,
    stp_res_if.source     o_res,
    stp_cfg_if.sink       i_cfg
);
    import stp_pkg::*;

    t_cls cls;
    t_cmd cmd;
    logic accept;

    // Configuration writes are always taken; the registers live in the datapath.
    assign i_cfg.ready = 1'b1;

    // A new character may enter whenever the result register is free or is
    // being emptied in this cycle, so a pending result never blocks a
    // character for longer than the consumer takes to accept it.
    assign i_char.ready = cls.out_free;
    assign accept       = i_char.valid && i_char.ready;

    stp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cls    (cls),
        .o_cmd    (cmd)
    );

    stp_dp #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_ch         (i_char.ch),
        .i_start      (i_char.start_req),
        .i_cmd        (cmd),
        .o_cls        (cls),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .o_value      (o_res.value),
        .o_end_offset (o_res.end_offset),
        .o_status     (o_res.status)
    );

endmodule
